[sv/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with active-low reset disable
`define CPLS_ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// shorthand on the usual clk / rst_n pair
`define CPLS_ASSERT(lbl, prop, msg) \
  `CPLS_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

[sv/cpls_pkg.sv]
// shared constants, types and helper functions of the profile scheduler
package cpls_pkg;

  localparam int MAX_STEPS = 64;
  localparam int IDX_W     = $clog2(MAX_STEPS);
  localparam int CNT_W     = $clog2(MAX_STEPS + 1);
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 8;

  localparam logic [DATA_W-1:0] TIME_INF = {DATA_W{1'b1}};

  // result status codes
  localparam logic [1:0] ST_PLACED  = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EARLIER = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HORIZON  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = CFG_IDX_W'(1);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] word_t;

  // profile memories: time and free share the write side
  typedef struct packed {
    logic  we;
    idx_t  waddr;
    word_t wtime;
    word_t wfree;
    idx_t  raddr_time;
    idx_t  raddr_free;
  } prof_port_t;

  // scratch memory holding the rebuilt profile
  typedef struct packed {
    logic                  we;
    idx_t                  waddr;
    logic [2*DATA_W-1:0]   wdata;
    idx_t                  raddr;
  } scr_port_t;

  function automatic word_t take_sat(word_t f, word_t d);
    return (f >= d) ? (f - d) : '0;
  endfunction

  function automatic word_t give_sat(word_t f, word_t d);
    logic [DATA_W:0] s;
    s = {1'b0, f} + {1'b0, d};
    return s[DATA_W] ? TIME_INF : s[DATA_W-1:0];
  endfunction

endpackage

[sv/cpls_in_if.sv]
// task input channel
interface cpls_in_if;
  import cpls_pkg::*;

  logic        valid;
  logic        ready;
  word_t       task_length;
  word_t       task_demand;
  logic        last_task;

  modport source (output valid, output task_length, output task_demand,
                  output last_task, input ready);
  modport sink   (input valid, input task_length, input task_demand,
                  input last_task, output ready);
endinterface

[sv/cpls_out_if.sv]
// result channel
interface cpls_out_if;
  import cpls_pkg::*;

  logic        valid;
  logic        ready;
  word_t       start_time;
  logic [1:0]  status;
  logic        end_of_problem;

  modport source (output valid, output start_time, output status,
                  output end_of_problem, input ready);
  modport sink   (input valid, input start_time, input status,
                  input end_of_problem, output ready);
endinterface

[sv/cpls_cfg_if.sv]
// configuration write channel
interface cpls_cfg_if;
  import cpls_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  word_t                wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

[sv/cpls_ram.sv]
// generic single write port ram with one registered read port
module cpls_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/cpls_seq.sv]
// sequencer and shared datapath: profile walk, rebuild and copy-back
module cpls_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  cpls_pkg::word_t     horizon,
  input  cpls_pkg::word_t     capacity,
  input  logic                restart_req,
  cpls_in_if.sink             in_ch,
  cpls_out_if.source          out_ch,
  output cpls_pkg::prof_port_t prof_o,
  input  cpls_pkg::word_t     t_rd,
  input  cpls_pkg::word_t     f_rd,
  output cpls_pkg::scr_port_t scr_o,
  input  logic [2*cpls_pkg::DATA_W-1:0] s_rd
);
  import cpls_pkg::*;

  typedef enum logic [9:0] {
    S_RST0  = 10'b0000000001,
    S_RST1  = 10'b0000000010,
    S_IDLE  = 10'b0000000100,
    S_W0    = 10'b0000001000,
    S_WALK  = 10'b0000010000,
    S_CHECK = 10'b0000100000,
    S_SCAN  = 10'b0001000000,
    S_TAIL  = 10'b0010000000,
    S_COPY  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t          state_r, state_nxt;
  word_t           len_r, len_nxt;
  word_t           dem_r, dem_nxt;
  logic            last_r, last_nxt;
  cnt_t            cur_r, cur_nxt;
  cnt_t            j_r, j_nxt;
  cnt_t            s_r, s_nxt;
  cnt_t            k_r, k_nxt;
  cnt_t            n_r, n_nxt;
  word_t           t_cur_r, t_cur_nxt;
  word_t           f_cur_r, f_cur_nxt;
  word_t           astart_r, astart_nxt;
  logic [DATA_W:0] end_r, end_nxt;
  word_t           lastf_r, lastf_nxt;
  word_t           prev_r, prev_nxt;
  logic            failed_r, failed_nxt;
  logic [1:0]      stat_r, stat_nxt;
  logic            ovld_r, ovld_nxt;
  word_t           ostart_r, ostart_nxt;
  logic [1:0]      ostat_r, ostat_nxt;
  logic            oeop_r, oeop_nxt;

  logic            in_acc;
  cnt_t            n_m1, cur_p1, cur_p2, j_p1, k_p1;
  logic            next_le, adv, at_end, in_range, need_ins, full;
  word_t           astart_w, take_w, give_w;
  logic [DATA_W:0] end_w, t_rd_x;

  assign in_ch.ready       = (state_r == S_IDLE) && !restart_req;
  assign in_acc            = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = ovld_r;
  assign out_ch.start_time = ostart_r;
  assign out_ch.status     = ostat_r;
  assign out_ch.end_of_problem = oeop_r;

  // shared compare / add unit inputs
  assign n_m1     = n_r - cnt_t'(1);
  assign cur_p1   = cur_r + cnt_t'(1);
  assign cur_p2   = cur_r + cnt_t'(2);
  assign j_p1     = j_r + cnt_t'(1);
  assign k_p1     = k_r + cnt_t'(1);
  assign t_rd_x   = {1'b0, t_rd};
  assign at_end   = (cur_r == n_m1);
  assign next_le  = (cur_p1 < n_m1) && (t_rd <= prev_r);
  assign adv      = next_le || (f_rd < dem_r);
  assign astart_w = (t_cur_r > prev_r) ? t_cur_r : prev_r;
  assign end_w    = {1'b0, astart_r} + {1'b0, len_r};
  assign in_range = (j_r < n_m1) && (t_rd_x < end_r);
  assign need_ins = (j_r == n_m1) || (t_rd_x > end_r);
  assign full     = (s_r >= cnt_t'(MAX_STEPS));
  assign take_w   = take_sat((state_r == S_CHECK) ? f_cur_r : f_rd, dem_r);
  assign give_w   = give_sat(lastf_r, dem_r);

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    dem_nxt    = dem_r;
    last_nxt   = last_r;
    cur_nxt    = cur_r;
    j_nxt      = j_r;
    s_nxt      = s_r;
    k_nxt      = k_r;
    n_nxt      = n_r;
    t_cur_nxt  = t_cur_r;
    f_cur_nxt  = f_cur_r;
    astart_nxt = astart_r;
    end_nxt    = end_r;
    lastf_nxt  = lastf_r;
    prev_nxt   = prev_r;
    failed_nxt = failed_r;
    stat_nxt   = stat_r;
    ostart_nxt = ostart_r;
    ostat_nxt  = ostat_r;
    oeop_nxt   = oeop_r;
    ovld_nxt   = ovld_r && !out_ch.ready;

    prof_o            = '0;
    scr_o             = '0;

    unique case (state_r)
      S_RST0: begin
        prof_o.we    = 1'b1;
        prof_o.waddr = idx_t'(0);
        prof_o.wtime = '0;
        prof_o.wfree = capacity;
        n_nxt        = cnt_t'(2);
        prev_nxt     = '0;
        failed_nxt   = 1'b0;
        state_nxt    = S_RST1;
      end
      S_RST1: begin
        prof_o.we    = 1'b1;
        prof_o.waddr = idx_t'(1);
        prof_o.wtime = TIME_INF;
        prof_o.wfree = capacity;
        state_nxt    = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          len_nxt  = in_ch.task_length;
          dem_nxt  = in_ch.task_demand;
          last_nxt = in_ch.last_task;
          if (failed_r) begin
            stat_nxt  = ST_EARLIER;
            state_nxt = S_DONE;
          end else if (in_ch.task_demand > capacity) begin
            stat_nxt  = ST_MISS;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_W0;
          end
        end
      end
      S_W0: begin
        t_cur_nxt         = t_rd;
        cur_nxt           = '0;
        prof_o.raddr_time = idx_t'(1);
        prof_o.raddr_free = idx_t'(0);
        state_nxt         = S_WALK;
      end
      S_WALK: begin
        // reads run one entry ahead of the decision
        prof_o.raddr_time = cur_p2[IDX_W-1:0];
        prof_o.raddr_free = cur_p1[IDX_W-1:0];
        if (at_end) begin
          stat_nxt  = ST_MISS;
          state_nxt = S_DONE;
        end else if (adv) begin
          t_cur_nxt = t_rd;
          cur_nxt   = cur_p1;
        end else begin
          astart_nxt = astart_w;
          prev_nxt   = astart_w;
          f_cur_nxt  = f_rd;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        end_nxt = end_w;
        if (end_w > {1'b0, horizon}) begin
          stat_nxt  = ST_MISS;
          state_nxt = S_DONE;
        end else if (last_r) begin
          stat_nxt  = ST_PLACED;
          state_nxt = S_DONE;
        end else begin
          scr_o.we          = 1'b1;
          scr_o.waddr       = idx_t'(0);
          scr_o.wdata       = {astart_r, take_w};
          lastf_nxt         = take_w;
          s_nxt             = cnt_t'(1);
          j_nxt             = cur_p1;
          prof_o.raddr_time = cur_p1[IDX_W-1:0];
          prof_o.raddr_free = cur_p1[IDX_W-1:0];
          state_nxt         = S_SCAN;
        end
      end
      S_SCAN: begin
        if (in_range) begin
          prof_o.raddr_time = j_p1[IDX_W-1:0];
          prof_o.raddr_free = j_p1[IDX_W-1:0];
          if (full) begin
            stat_nxt  = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            scr_o.we    = 1'b1;
            scr_o.waddr = s_r[IDX_W-1:0];
            scr_o.wdata = {t_rd, take_w};
            lastf_nxt   = take_w;
            s_nxt       = s_r + cnt_t'(1);
            j_nxt       = j_p1;
          end
        end else begin
          // re-read the same entry for the tail copy
          prof_o.raddr_time = j_r[IDX_W-1:0];
          prof_o.raddr_free = j_r[IDX_W-1:0];
          if (need_ins) begin
            if (full) begin
              stat_nxt  = ST_FULL;
              state_nxt = S_DONE;
            end else begin
              scr_o.we    = 1'b1;
              scr_o.waddr = s_r[IDX_W-1:0];
              scr_o.wdata = {end_r[DATA_W-1:0], give_w};
              s_nxt       = s_r + cnt_t'(1);
              state_nxt   = S_TAIL;
            end
          end else begin
            state_nxt = S_TAIL;
          end
        end
      end
      S_TAIL: begin
        prof_o.raddr_time = j_p1[IDX_W-1:0];
        prof_o.raddr_free = j_p1[IDX_W-1:0];
        if (full) begin
          stat_nxt  = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          scr_o.we    = 1'b1;
          scr_o.waddr = s_r[IDX_W-1:0];
          scr_o.wdata = {t_rd, f_rd};
          s_nxt       = s_r + cnt_t'(1);
          j_nxt       = j_p1;
          if (j_r == n_m1) begin
            k_nxt     = '0;
            state_nxt = S_COPY;
          end
        end
      end
      S_COPY: begin
        scr_o.raddr  = k_p1[IDX_W-1:0];
        prof_o.we    = 1'b1;
        prof_o.waddr = k_r[IDX_W-1:0];
        prof_o.wtime = s_rd[2*DATA_W-1:DATA_W];
        prof_o.wfree = s_rd[DATA_W-1:0];
        k_nxt        = k_p1;
        if (k_p1 == s_r) begin
          n_nxt     = s_r;
          stat_nxt  = ST_PLACED;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovld_r || out_ch.ready) begin
          ovld_nxt   = 1'b1;
          ostart_nxt = (stat_r == ST_PLACED) ? astart_r : '0;
          ostat_nxt  = stat_r;
          oeop_nxt   = last_r;
          failed_nxt = failed_r || (stat_r != ST_PLACED);
          state_nxt  = last_r ? S_RST0 : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_RST0;
      end
    endcase

    if (restart_req) begin
      state_nxt = S_RST0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_RST0;
      ovld_r   <= 1'b0;
      failed_r <= 1'b0;
      n_r      <= cnt_t'(2);
      prev_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      ovld_r   <= ovld_nxt;
      failed_r <= failed_nxt;
      n_r      <= n_nxt;
      prev_r   <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r    <= len_nxt;
    dem_r    <= dem_nxt;
    last_r   <= last_nxt;
    cur_r    <= cur_nxt;
    j_r      <= j_nxt;
    s_r      <= s_nxt;
    k_r      <= k_nxt;
    t_cur_r  <= t_cur_nxt;
    f_cur_r  <= f_cur_nxt;
    astart_r <= astart_nxt;
    end_r    <= end_nxt;
    lastf_r  <= lastf_nxt;
    stat_r   <= stat_nxt;
    ostart_r <= ostart_nxt;
    ostat_r  <= ostat_nxt;
    oeop_r   <= oeop_nxt;
  end

endmodule

[sv/cumulative_profile_list_scheduler.sv]
// top level: configuration registers, profile and scratch memories, sequencer
// a task refused up front (earlier failure, demand too large) goes straight to its result;
//   any other task walks the old profile of n steps and, unless it misses or is the last, rebuilds
//   the new one of s steps (at most MAX_STEPS) and copies it back; one read port per memory paces it
// throughput: one task at a time; the next is taken once the result sits in the output beat
// reset: synchronous, active low; a profile restart (states RST0, RST1) follows reset, the last task
//   of a problem and every capacity write, with the input not ready meanwhile
module cumulative_profile_list_scheduler (
  input  logic       clk,
  input  logic       rst_n,
  cpls_in_if.sink    in_ch,
  cpls_out_if.source out_ch,
  cpls_cfg_if.sink   cfg_ch
);
  import cpls_pkg::*;

  word_t               horizon_r;
  word_t               capacity_r;
  logic                cfg_acc;
  logic                cap_wr;
  prof_port_t          prof;
  scr_port_t           scr;
  word_t               t_rd;
  word_t               f_rd;
  logic [2*DATA_W-1:0] s_rd;

  // register writes are always taken; unknown indexes are dropped
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;
  // a capacity write restarts the problem, the sequencer holds input off for it
  assign cap_wr       = cfg_acc && (cfg_ch.reg_index == REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      horizon_r  <= '0;
      capacity_r <= '0;
    end else if (cfg_acc) begin
      unique case (cfg_ch.reg_index)
        REG_HORIZON:  horizon_r  <= cfg_ch.wr_data;
        REG_CAPACITY: capacity_r <= cfg_ch.wr_data;
        default: begin
        end
      endcase
    end
  end

  // breakpoint times, read one entry ahead of the free amounts during the walk
  cpls_ram #(.DEPTH(MAX_STEPS), .WIDTH(DATA_W)) u_time_ram (
    .clk   (clk),
    .we    (prof.we),
    .waddr (prof.waddr),
    .wdata (prof.wtime),
    .raddr (prof.raddr_time),
    .rdata (t_rd)
  );

  // free capacity of each step
  cpls_ram #(.DEPTH(MAX_STEPS), .WIDTH(DATA_W)) u_free_ram (
    .clk   (clk),
    .we    (prof.we),
    .waddr (prof.waddr),
    .wdata (prof.wfree),
    .raddr (prof.raddr_free),
    .rdata (f_rd)
  );

  // rebuilt profile, copied back only once it is known to fit
  cpls_ram #(.DEPTH(MAX_STEPS), .WIDTH(2*DATA_W)) u_scr_ram (
    .clk   (clk),
    .we    (scr.we),
    .waddr (scr.waddr),
    .wdata (scr.wdata),
    .raddr (scr.raddr),
    .rdata (s_rd)
  );

  // walk, horizon check, rebuild and copy-back all share the sequencer's compare / add logic
  cpls_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .horizon     (horizon_r),
    .capacity    (capacity_r),
    .restart_req (cap_wr),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .prof_o      (prof),
    .t_rd        (t_rd),
    .f_rd        (f_rd),
    .scr_o       (scr),
    .s_rd        (s_rd)
  );

endmodule

[sv/cpls_checker.sv]
// port-level checker for the profile scheduler, bound to the top level
`include "assert_macros.svh"

module cpls_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input cpls_pkg::word_t            out_start,
  input logic [1:0]                 out_status,
  input logic                       out_eop,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [cpls_pkg::CFG_IDX_W-1:0] cfg_index
);
  import cpls_pkg::*;

  logic in_acc, out_acc, cap_wr;
  logic fail_seen_r, fail_seen_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign cap_wr  = cfg_valid && cfg_ready && (cfg_index == REG_CAPACITY);

  // a failed result seen earlier in the current problem
  always_comb begin
    fail_seen_nxt = fail_seen_r;
    if (out_acc) begin
      fail_seen_nxt = !out_eop && (fail_seen_r || (out_status != ST_PLACED));
    end
    if (cap_wr) begin
      fail_seen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_seen_r <= 1'b0;
    end else begin
      fail_seen_r <= fail_seen_nxt;
    end
  end

  `CPLS_ASSERT(a_busy_after_accept, in_acc |=> !in_ready, "input ready right after a task")
  `CPLS_ASSERT(a_start_zero, (out_valid && (out_status != ST_PLACED)) |-> (out_start == '0), "start not zero on failure")
  `CPLS_ASSERT(a_earlier_needs_fail, (out_acc && (out_status == ST_EARLIER)) |-> fail_seen_r, "earlier-failure status without a failure")
  `CPLS_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_start) && $stable(out_status) && $stable(out_eop)), "result beat changed while stalled")

endmodule

bind cumulative_profile_list_scheduler cpls_checker u_cpls_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_start  (out_ch.start_time),
  .out_status (out_ch.status),
  .out_eop    (out_ch.end_of_problem),
  .cfg_valid  (cfg_ch.valid),
  .cfg_ready  (cfg_ch.ready),
  .cfg_index  (cfg_ch.reg_index)
);
